FILE: src/awbc_pkg.sv
`timescale 1ns / 1ps
package awbc_pkg;

	localparam int SAMPLE_W = 12;
	localparam int BOUND_W = 13;
	localparam int BAND_W = 3;
	localparam int NUM_BANDS = 4;
	localparam int CFG_IDX_W = 4;

	localparam int DEF_WINDOW_DEPTH = 8;
	localparam int DEF_JUMP_THRESHOLD = 250;

	// Entries in the queue between the front and back halves
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QLVL_W = $clog2(QDEPTH + 1);

	localparam logic [BOUND_W-1:0] PREV_RESET = BOUND_W'(4096);

	localparam logic [BAND_W-1:0] BAND_NONE = 3'd0;

	// register indexes
	localparam logic [CFG_IDX_W-1:0] REG_B1_LO = 4'd0;
	localparam logic [CFG_IDX_W-1:0] REG_B1_HI = 4'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B2_LO = 4'd2;
	localparam logic [CFG_IDX_W-1:0] REG_B2_HI = 4'd3;
	localparam logic [CFG_IDX_W-1:0] REG_B3_LO = 4'd4;
	localparam logic [CFG_IDX_W-1:0] REG_B3_HI = 4'd5;
	localparam logic [CFG_IDX_W-1:0] REG_B4_LO = 4'd6;
	localparam logic [CFG_IDX_W-1:0] REG_B4_HI = 4'd7;

	localparam logic [SAMPLE_W-1:0] LO_RESET [NUM_BANDS] = '{
		12'd528, 12'd789, 12'd679, 12'd1846
	};
	localparam logic [BOUND_W-1:0] HI_RESET [NUM_BANDS] = '{
		13'd646, 13'd965, 13'd830, 13'd2257
	};

	typedef struct packed {
		logic                jump;
		logic [SAMPLE_W-1:0] win_min;
		logic [SAMPLE_W-1:0] win_max;
	} awbc_entry_t;

	typedef struct packed {
		logic [NUM_BANDS-1:0][SAMPLE_W-1:0] lo;
		logic [NUM_BANDS-1:0][BOUND_W-1:0]  hi;
	} awbc_bands_t;

endpackage

FILE: src/adc_window_band_classifier.sv
`timescale 1ns / 1ps
// ADC window band classifier. Each accepted sample goes into a ring of
// WINDOW_DEPTH entries (cleared to zero at reset); the result reports the
// min and max over the ring after that write, the first of four bands
// (1..4, else 0) whose low bound lies strictly below the min and whose
// high bound lies strictly above the max, and a jump flag that is set when
// the sample exceeds the previous one by more than JUMP_THRESHOLD (never on
// the first sample after reset). One sample per clock is accepted while
// in_ready is high, which needs a queue slot free beyond the stage-1 item;
// a result passes through the stage-1 register and the queue into the
// output register. The rate is set by the ring write plus a combinational
// min/max tree over the ring in the front half; a four-entry queue and the
// output register let input and output stall independently. The user must
// write band bounds through cfg_we/cfg_index/cfg_data only while the block
// is idle; the block does not enforce this. Indexes above 7 are ignored.
module adc_window_band_classifier import awbc_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int JUMP_THRESHOLD = DEF_JUMP_THRESHOLD
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic [SAMPLE_W-1:0]  sample,
	output logic                 out_valid,
	input  logic                 out_ready,
	output logic [BAND_W-1:0]    band_code,
	output logic                 jump_detected,
	output logic [SAMPLE_W-1:0]  window_min,
	output logic [SAMPLE_W-1:0]  window_max,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [BOUND_W-1:0]   cfg_data
);

	awbc_bands_t       bands_q;
	logic              push;
	awbc_entry_t       push_data;
	logic              pop;
	logic              q_valid;
	awbc_entry_t       q_data;
	logic [QLVL_W-1:0] q_level;

	// band bound registers: lows keep 12 bits, highs 13
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int b = 0; b < NUM_BANDS; b++) begin
				bands_q.lo[b] <= LO_RESET[b];
				bands_q.hi[b] <= HI_RESET[b];
			end
		end else if (cfg_we) begin
			case (cfg_index)
				REG_B1_LO: bands_q.lo[0] <= cfg_data[SAMPLE_W-1:0];
				REG_B1_HI: bands_q.hi[0] <= cfg_data;
				REG_B2_LO: bands_q.lo[1] <= cfg_data[SAMPLE_W-1:0];
				REG_B2_HI: bands_q.hi[1] <= cfg_data;
				REG_B3_LO: bands_q.lo[2] <= cfg_data[SAMPLE_W-1:0];
				REG_B3_HI: bands_q.hi[2] <= cfg_data;
				REG_B4_LO: bands_q.lo[3] <= cfg_data[SAMPLE_W-1:0];
				REG_B4_HI: bands_q.hi[3] <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: ring, jump test, min/max
	awbc_front #(
		.WINDOW_DEPTH(WINDOW_DEPTH),
		.JUMP_THRESHOLD(JUMP_THRESHOLD)
	) u_front (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.sample(sample),
		.q_level(q_level),
		.push(push),
		.push_data(push_data)
	);

	// decoupling queue
	awbc_fifo u_fifo (
		.clk(clk),
		.arst_n(arst_n),
		.push(push),
		.push_data(push_data),
		.pop(pop),
		.q_valid(q_valid),
		.q_data(q_data),
		.q_level(q_level)
	);

	// back: band match and output register
	awbc_back u_back (
		.clk(clk),
		.arst_n(arst_n),
		.q_valid(q_valid),
		.q_data(q_data),
		.pop(pop),
		.bands(bands_q),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.band_code(band_code),
		.jump_detected(jump_detected),
		.window_min(window_min),
		.window_max(window_max)
	);

`ifndef SYNTHESIS
	// queue never holds more than its depth
	assert property (@(posedge clk) disable iff (!arst_n)
		q_level <= QLVL_W'(QDEPTH))
		else $error("queue level above depth");

	// a new request is only taken when the queue has a free slot
	assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> q_level < QLVL_W'(QDEPTH))
		else $error("request taken with queue full");

	// min and max come from the same ring snapshot
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> window_min <= window_max)
		else $error("window min above window max");

	// a pushed entry with no pop raises the queue level in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		push && !pop |=> q_level == $past(q_level) + 1'b1)
		else $error("queue push lost");
`endif

endmodule

FILE: src/awbc_front.sv
`timescale 1ns / 1ps
module awbc_front import awbc_pkg::*; #(
	parameter int WINDOW_DEPTH = DEF_WINDOW_DEPTH,
	parameter int JUMP_THRESHOLD = DEF_JUMP_THRESHOLD
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  logic [SAMPLE_W-1:0] sample,
	input  logic [QLVL_W-1:0]   q_level,
	output logic                push,
	output awbc_entry_t         push_data
);

	localparam int PW = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int PAD = 1 << PW;

	logic [SAMPLE_W-1:0] ring_q [WINDOW_DEPTH];
	logic [PW-1:0]       wr_ptr_q;
	logic [BOUND_W-1:0]  prev_q;
	logic                valid_s1;
	logic                jump_s1;
	logic                accept;
	logic                jump_d;
	logic [QLVL_W:0]     used;
	logic signed [BOUND_W:0] diff;
	logic [SAMPLE_W-1:0] mn_tree [1:2*PAD-1];
	logic [SAMPLE_W-1:0] mx_tree [1:2*PAD-1];

	// queue slots taken, counting the request still in stage 1
	assign used = {1'b0, q_level} + (QLVL_W+1)'(valid_s1);
	assign in_ready = used < (QLVL_W+1)'(QDEPTH);
	assign accept = in_valid && in_ready;

	assign diff = $signed({2'b00, sample}) - $signed({1'b0, prev_q});
	assign jump_d = diff > $signed((BOUND_W+1)'(JUMP_THRESHOLD));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < WINDOW_DEPTH; i++) begin
				ring_q[i] <= '0;
			end
			wr_ptr_q <= '0;
			prev_q <= PREV_RESET;
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= accept;
			if (accept) begin
				for (int i = 0; i < WINDOW_DEPTH; i++) begin
					if (wr_ptr_q == PW'(i)) begin
						ring_q[i] <= sample;
					end
				end
				prev_q <= {1'b0, sample};
				if (wr_ptr_q == PW'(WINDOW_DEPTH - 1)) begin
					wr_ptr_q <= '0;
				end else begin
					wr_ptr_q <= wr_ptr_q + 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			jump_s1 <= jump_d;
		end
	end

	// min/max tree over the ring; spare leaves repeat entry 0
	always_comb begin
		for (int i = 0; i < PAD; i++) begin
			if (i < WINDOW_DEPTH) begin
				mn_tree[PAD + i] = ring_q[i];
				mx_tree[PAD + i] = ring_q[i];
			end else begin
				mn_tree[PAD + i] = ring_q[0];
				mx_tree[PAD + i] = ring_q[0];
			end
		end
		for (int i = PAD - 1; i >= 1; i--) begin
			mn_tree[i] = (mn_tree[2*i] < mn_tree[2*i+1]) ? mn_tree[2*i] : mn_tree[2*i+1];
			mx_tree[i] = (mx_tree[2*i] > mx_tree[2*i+1]) ? mx_tree[2*i] : mx_tree[2*i+1];
		end
	end

	// ring holds exactly the stage-1 item's view during this cycle
	assign push = valid_s1;
	assign push_data = '{jump: jump_s1, win_min: mn_tree[1], win_max: mx_tree[1]};

endmodule

FILE: src/awbc_fifo.sv
`timescale 1ns / 1ps
module awbc_fifo import awbc_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  awbc_entry_t       push_data,
	input  logic              pop,
	output logic              q_valid,
	output awbc_entry_t       q_data,
	output logic [QLVL_W-1:0] q_level
);

	awbc_entry_t       slot_q [QDEPTH];
	logic [QPTR_W-1:0] wr_q;
	logic [QPTR_W-1:0] rd_q;
	logic [QLVL_W-1:0] level_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			level_q <= '0;
		end else begin
			if (push) begin
				wr_q <= wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= rd_q + 1'b1;
			end
			if (push && !pop) begin
				level_q <= level_q + 1'b1;
			end else if (pop && !push) begin
				level_q <= level_q - 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= push_data;
		end
	end

	assign q_valid = level_q != '0;
	assign q_data = slot_q[rd_q];
	assign q_level = level_q;

endmodule

FILE: src/awbc_back.sv
`timescale 1ns / 1ps
module awbc_back import awbc_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                q_valid,
	input  awbc_entry_t         q_data,
	output logic                pop,
	input  awbc_bands_t         bands,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [BAND_W-1:0]   band_code,
	output logic                jump_detected,
	output logic [SAMPLE_W-1:0] window_min,
	output logic [SAMPLE_W-1:0] window_max
);

	logic                out_valid_q;
	logic [BAND_W-1:0]   band_q;
	logic                jump_q;
	logic [SAMPLE_W-1:0] min_q;
	logic [SAMPLE_W-1:0] max_q;
	logic [BAND_W-1:0]   band_d;

	// lowest numbered matching band wins: scan from the top down
	always_comb begin
		band_d = BAND_NONE;
		for (int b = NUM_BANDS - 1; b >= 0; b--) begin
			if (q_data.win_min > bands.lo[b] && {1'b0, q_data.win_max} < bands.hi[b]) begin
				band_d = BAND_W'(b + 1);
			end
		end
	end

	assign pop = q_valid && (!out_valid_q || out_ready);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (!out_valid_q || out_ready) begin
			out_valid_q <= q_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			band_q <= band_d;
			jump_q <= q_data.jump;
			min_q <= q_data.win_min;
			max_q <= q_data.win_max;
		end
	end

	assign out_valid = out_valid_q;
	assign band_code = band_q;
	assign jump_detected = jump_q;
	assign window_min = min_q;
	assign window_max = max_q;

endmodule
